/* rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX0 = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_HEX2 = 3'd5,
        MODE_HEX3 = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        ST_BYTE     = 4'd0,
        ST_DONE     = 4'd1,
        ST_NO_OPEN  = 4'd2,
        ST_END_IDLE = 4'd3,
        ST_BAD_ESC  = 4'd4,
        ST_BAD_HEX  = 4'd5,
        ST_CUT_ESC  = 4'd6,
        ST_CUT_UNI  = 4'd7,
        ST_UNTERM   = 4'd8
    } status_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [7:0] UTF_CONT = 8'h80;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [5:0] UTF_LOW_MASK = 6'h3F;
    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;

    localparam int unsigned MAX_RES = 3;

endpackage

`default_nettype wire

/* rtl/jsu_in_if.sv */
// Source byte channel of the JSON string unescaper.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       source_end;

    modport source (output valid, data_byte, source_end, input ready);
    modport sink (input valid, data_byte, source_end, output ready);
endinterface

`default_nettype wire

/* rtl/jsu_out_if.sv */
// Result channel of the JSON string unescaper.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink (input valid, out_byte, status, last, output ready);
endinterface

`default_nettype wire

/* rtl/json_string_unescape_utf8.sv */
// Top level: JSON string unescaper with BMP-only UTF-8 output.
// Depends on jsu_pkg, jsu_in_if and jsu_out_if.
//
//   channel | dir | payload                      | one request is
//   src     | in  | data_byte, source_end        | one source byte or end mark
//   res     | out | out_byte, status, last       | one decoded byte or status
//
// A request lands in an input register and is decoded from there into a group of
// zero to three results; a non-empty group is held in a result register. One
// request per cycle is taken while the result side is ready and each yields at most
// one result. A \u escape expanding to two or three bytes holds the next request
// that yields a result while the result register drains. Reset returns to idle,
// awaiting an opening quote. A stalled result side fills both registers, then
// drops src.ready.
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    jsu_in_if.sink      src,
    jsu_out_if.source   res
);

    logic        a_valid_reg;
    logic [7:0]  a_byte_reg;
    logic        a_end_reg;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [11:0] accum_reg;
    logic [11:0] accum_next;

    logic [1:0]  b_cnt_reg;
    logic [1:0]  b_idx_reg;
    logic [7:0]  b_byte_reg [MAX_RES];
    status_t     b_status_reg;

    logic [1:0]  dec_cnt;
    logic [7:0]  dec_byte [MAX_RES];
    status_t     dec_status;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp;

    logic        out_fire;
    logic        out_last;
    logic        b_free;
    logic        a_retire;
    logic        in_fire;

    always_comb
    begin
        hex_ok = 1'b0;
        hex_val = 4'd0;
        if (a_byte_reg >= 8'h30 && a_byte_reg <= 8'h39)
        begin
            hex_ok = 1'b1;
            hex_val = a_byte_reg[3:0];
        end
        else if ((a_byte_reg >= 8'h61 && a_byte_reg <= 8'h66)
                 || (a_byte_reg >= 8'h41 && a_byte_reg <= 8'h46))
        begin
            hex_ok = 1'b1;
            hex_val = a_byte_reg[3:0] + 4'd9;
        end
    end

    assign cp = {accum_reg, hex_val};

    always_comb
    begin
        dec_cnt = 2'd0;
        dec_status = ST_BYTE;
        for (int i = 0; i < MAX_RES; i++)
        begin
            dec_byte[i] = 8'h00;
        end

        unique case (mode_reg) inside
            MODE_STR:
            begin
                if (a_end_reg)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_UNTERM;
                end
                else if (a_byte_reg == CH_QUOTE)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_DONE;
                end
                else if (a_byte_reg != CH_BSLASH)
                begin
                    dec_cnt = 2'd1;
                    dec_byte[0] = a_byte_reg;
                end
            end

            MODE_ESC:
            begin
                if (a_end_reg)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_CUT_ESC;
                end
                else
                begin
                    dec_cnt = 2'd1;
                    unique case (a_byte_reg) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: dec_byte[0] = a_byte_reg;
                        CH_B: dec_byte[0] = CTL_BS;
                        CH_F: dec_byte[0] = CTL_FF;
                        CH_N: dec_byte[0] = CTL_LF;
                        CH_R: dec_byte[0] = CTL_CR;
                        CH_T: dec_byte[0] = CTL_TAB;
                        CH_U: dec_cnt = 2'd0;
                        default:
                        begin
                            dec_status = ST_BAD_ESC;
                        end
                    endcase
                end
            end

            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3:
            begin
                if (a_end_reg)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_CUT_UNI;
                end
                else if (!hex_ok)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_BAD_HEX;
                end
                else if (mode_reg == MODE_HEX3)
                begin
                    if (cp < CP_ONE_LIMIT)
                    begin
                        dec_cnt = 2'd1;
                        dec_byte[0] = cp[7:0];
                    end
                    else if (cp < CP_TWO_LIMIT)
                    begin
                        dec_cnt = 2'd2;
                        dec_byte[0] = UTF_LEAD2 | {3'd0, cp[10:6]};
                        dec_byte[1] = UTF_CONT | {2'd0, cp[5:0] & UTF_LOW_MASK};
                    end
                    else
                    begin
                        dec_cnt = 2'd3;
                        dec_byte[0] = UTF_LEAD3 | {4'd0, cp[15:12]};
                        dec_byte[1] = UTF_CONT | {2'd0, cp[11:6] & UTF_LOW_MASK};
                        dec_byte[2] = UTF_CONT | {2'd0, cp[5:0] & UTF_LOW_MASK};
                    end
                end
            end

            default:
            begin
                if (a_end_reg)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_END_IDLE;
                end
                else if (a_byte_reg != CH_QUOTE)
                begin
                    dec_cnt = 2'd1;
                    dec_status = ST_NO_OPEN;
                end
            end
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        accum_next = accum_reg;
        if (dec_status != ST_BYTE)
        begin
            mode_next = MODE_IDLE;
            accum_next = 12'd0;
        end
        else
        begin
            unique case (mode_reg) inside
                MODE_STR:
                begin
                    if (a_byte_reg == CH_BSLASH)
                        mode_next = MODE_ESC;
                end
                MODE_ESC:
                begin
                    mode_next = MODE_STR;
                    if (a_byte_reg == CH_U)
                    begin
                        mode_next = MODE_HEX0;
                        accum_next = 12'd0;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2:
                begin
                    accum_next = {accum_reg[7:0], hex_val};
                    mode_next = mode_t'(mode_reg + 3'd1);
                end
                MODE_HEX3:
                begin
                    mode_next = MODE_STR;
                    accum_next = 12'd0;
                end
                default:
                begin
                    mode_next = MODE_STR;
                    accum_next = 12'd0;
                end
            endcase
        end
    end

    assign out_last = (b_idx_reg == b_cnt_reg - 2'd1);
    assign out_fire = res.valid && res.ready;
    assign b_free = (b_cnt_reg == 2'd0) || (out_fire && out_last);
    assign a_retire = a_valid_reg && ((dec_cnt == 2'd0) || b_free);
    assign in_fire = src.valid && src.ready;

    assign src.ready = !a_valid_reg || a_retire;

    assign res.valid = (b_cnt_reg != 2'd0);
    assign res.out_byte = b_byte_reg[b_idx_reg];
    assign res.status = b_status_reg;
    assign res.last = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            mode_reg <= MODE_IDLE;
            accum_reg <= 12'd0;
            b_cnt_reg <= 2'd0;
            b_idx_reg <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_retire)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_retire)
            begin
                mode_reg <= mode_next;
                accum_reg <= accum_next;
            end

            if (a_retire && dec_cnt != 2'd0)
            begin
                b_cnt_reg <= dec_cnt;
                b_idx_reg <= 2'd0;
            end
            else if (out_fire)
            begin
                if (out_last)
                begin
                    b_cnt_reg <= 2'd0;
                    b_idx_reg <= 2'd0;
                end
                else
                begin
                    b_idx_reg <= b_idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_byte_reg <= src.data_byte;
            a_end_reg <= src.source_end;
        end
        if (a_retire && dec_cnt != 2'd0)
        begin
            b_byte_reg <= dec_byte;
            b_status_reg <= dec_status;
        end
    end

endmodule

`default_nettype wire

/* bench/tb_json_string_unescape_utf8.sv */
// Testbench for json_string_unescape_utf8: drives source bytes and end marks, predicts
// the decoded bytes and status results, and checks every result field by field.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the json_string_unescape_utf8 RTL.
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int STIM_ITEMS = 470;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                               CH_B, CH_F, CH_N, CH_R, CH_T};

    typedef struct {
        logic [7:0] data_byte;
        logic       source_end;
        bit         drain;
    } src_req_t;

    typedef struct {
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } result_t;

    logic clk;
    logic rst_n;

    jsu_in_if  src_if ();
    jsu_out_if res_if ();

    json_string_unescape_utf8 uut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .res   (res_if)
    );

    src_req_t pending_reqs[$];
    result_t  expected_results[$];
    src_req_t next_req;
    result_t  exp_res;

    mode_t       dec_mode = MODE_IDLE;
    logic [11:0] hex_accum = '0;

    bit hold_next = 1'b0;
    int stim_total = 0;
    int accepted_cnt = 0;
    int results_cnt = 0;
    int strings_closed = 0;
    int error_results = 0;
    int error_cnt = 0;
    int src_gap = 0;
    int res_stall = 0;
    int stall_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        foreach (ESC_LETTERS[i])
        begin
            if (ESC_LETTERS[i] == c)
                return 1'b1;
        end
        return c == CH_U;
    endfunction

    function automatic void push_result(input logic [7:0] b, input status_t st,
                                        input logic is_last);
        result_t r;
        r.out_byte = b;
        r.status = st;
        r.last = is_last;
        expected_results = {expected_results, r};
    endfunction

    function automatic void close_string(input status_t st);
        push_result(8'h00, st, 1'b1);
        dec_mode = MODE_IDLE;
        hex_accum = '0;
    endfunction

    function automatic void predict_results(input logic [7:0] c, input logic req_end);
        int nib;
        logic [15:0] cp;
        nib = hex_nibble(c);
        case (dec_mode) inside
            MODE_STR:
            begin
                if (req_end)
                    close_string(ST_UNTERM);
                else if (c == CH_QUOTE)
                    close_string(ST_DONE);
                else if (c == CH_BSLASH)
                    dec_mode = MODE_ESC;
                else
                    push_result(c, ST_BYTE, 1'b1);
            end
            MODE_ESC:
            begin
                if (req_end)
                    close_string(ST_CUT_ESC);
                else
                begin
                    dec_mode = MODE_STR;
                    case (c) inside
                        CH_QUOTE, CH_BSLASH, CH_SLASH: push_result(c, ST_BYTE, 1'b1);
                        CH_B: push_result(CTL_BS, ST_BYTE, 1'b1);
                        CH_F: push_result(CTL_FF, ST_BYTE, 1'b1);
                        CH_N: push_result(CTL_LF, ST_BYTE, 1'b1);
                        CH_R: push_result(CTL_CR, ST_BYTE, 1'b1);
                        CH_T: push_result(CTL_TAB, ST_BYTE, 1'b1);
                        CH_U:
                        begin
                            dec_mode = MODE_HEX0;
                            hex_accum = '0;
                        end
                        default: close_string(ST_BAD_ESC);
                    endcase
                end
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3:
            begin
                if (req_end)
                    close_string(ST_CUT_UNI);
                else if (nib < 0)
                    close_string(ST_BAD_HEX);
                else if (dec_mode != MODE_HEX3)
                begin
                    hex_accum = {hex_accum[7:0], nib[3:0]};
                    dec_mode = mode_t'(dec_mode + 3'd1);
                end
                else
                begin
                    cp = {hex_accum, nib[3:0]};
                    hex_accum = '0;
                    dec_mode = MODE_STR;
                    if (cp < CP_ONE_LIMIT)
                        push_result(cp[7:0], ST_BYTE, 1'b1);
                    else if (cp < CP_TWO_LIMIT)
                    begin
                        push_result(UTF_LEAD2 | {3'b000, cp[10:6]}, ST_BYTE, 1'b0);
                        push_result(UTF_CONT | {2'b00, cp[5:0] & UTF_LOW_MASK}, ST_BYTE, 1'b1);
                    end
                    else
                    begin
                        push_result(UTF_LEAD3 | {4'b0000, cp[15:12]}, ST_BYTE, 1'b0);
                        push_result(UTF_CONT | {2'b00, cp[11:6]}, ST_BYTE, 1'b0);
                        push_result(UTF_CONT | {2'b00, cp[5:0] & UTF_LOW_MASK}, ST_BYTE, 1'b1);
                    end
                end
            end
            default:
            begin
                if (req_end)
                    close_string(ST_END_IDLE);
                else if (c == CH_QUOTE)
                begin
                    dec_mode = MODE_STR;
                    hex_accum = '0;
                end
                else
                    close_string(ST_NO_OPEN);
            end
        endcase
    endfunction

    function automatic void queue_req(input logic [7:0] b, input logic is_end);
        src_req_t r;
        r.data_byte = b;
        r.source_end = is_end;
        r.drain = hold_next;
        hold_next = 1'b0;
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        queue_req(b, 1'b0);
    endfunction

    function automatic void queue_end();
        queue_req(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == CH_QUOTE || v == CH_BSLASH);
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void queue_unicode();
        logic [15:0] cp;
        logic [15:0] edges_cp [6] = '{16'h0000, 16'h007F, 16'h0080,
                                      16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(0, 4))
            0: cp = 16'($urandom_range(0, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
            default: cp = edges_cp[$urandom_range(0, 5)];
        endcase
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        for (int i = 3; i >= 0; i--)
            queue_byte(hex_char(cp[i * 4 +: 4]));
    endfunction

    function automatic void queue_random_string();
        int segs;
        int kind;
        logic [7:0] v;
        if ($urandom_range(0, 19) == 0)
            hold_next = 1'b1;
        queue_byte(CH_QUOTE);
        segs = $urandom_range(0, 10);
        for (int i = 0; i < segs; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                queue_byte(plain_byte());
            else if (kind < 7)
            begin
                queue_byte(CH_BSLASH);
                queue_byte(ESC_LETTERS[$urandom_range(0, 7)]);
            end
            else
                queue_unicode();
        end
        case ($urandom_range(0, 11))
            0: queue_end();
            1:
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (is_escape_letter(v));
                queue_byte(CH_BSLASH);
                queue_byte(v);
            end
            2:
            begin
                queue_byte(CH_BSLASH);
                queue_end();
            end
            3, 4:
            begin
                queue_byte(CH_BSLASH);
                queue_byte(CH_U);
                segs = $urandom_range(0, 3);
                for (int i = 0; i < segs; i++)
                    queue_byte(hex_char(4'($urandom_range(0, 15))));
                if (kind[0])
                    queue_end();
                else
                begin
                    do
                        v = 8'($urandom_range(0, 255));
                    while (hex_nibble(v) >= 0);
                    queue_byte(v);
                end
            end
            default: queue_byte(CH_QUOTE);
        endcase
    endfunction

    function automatic bit idling_allowed();
        return (accepted_cnt < stim_total - 60) && ((accepted_cnt / 50) % 4 != 3);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_if.valid <= 1'b0;
            src_if.data_byte <= 8'h00;
            src_if.source_end <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (src_if.valid && src_if.ready)
            begin
                predict_results(src_if.data_byte, src_if.source_end);
                accepted_cnt++;
            end
            if (!src_if.valid || src_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_if.valid <= 1'b0;
                end
                else if (idling_allowed() && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(0, 11);
                    src_if.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && expected_results.size() != 0))
                begin
                    next_req = pending_reqs.pop_front();
                    src_if.data_byte <= next_req.data_byte;
                    src_if.source_end <= next_req.source_end;
                    src_if.valid <= 1'b1;
                end
                else
                    src_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            res_stall = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                results_cnt++;
                if (expected_results.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("ERROR: unexpected result byte=%02h status=%0d last=%0b",
                                 res_if.out_byte, res_if.status, res_if.last);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.status == ST_DONE)
                        strings_closed++;
                    else if (exp_res.status != ST_BYTE)
                        error_results++;
                    if (res_if.out_byte !== exp_res.out_byte ||
                        res_if.status !== 4'(exp_res.status) ||
                        res_if.last !== exp_res.last)
                    begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS)
                            $display({"ERROR: result %0d expected byte=%02h status=%0d ",
                                      "last=%0b, got byte=%02h status=%0d last=%0b"},
                                     results_cnt, exp_res.out_byte, exp_res.status,
                                     exp_res.last, res_if.out_byte, res_if.status,
                                     res_if.last);
                    end
                end
            end
            if (res_stall > 0)
            begin
                res_stall--;
                res_if.ready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 7) == 0)
            begin
                res_stall = $urandom_range(0, 11);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (src_if.valid && src_if.ready) || (res_if.valid && res_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", stall_cycles);
            $display("json_string_unescape_utf8 test failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        src_if.valid = 1'b0;
        src_if.data_byte = 8'h00;
        src_if.source_end = 1'b0;
        res_if.ready = 1'b0;

        // idle: end mark, stray byte, then a string with extremes and a three-byte escape
        queue_end();
        queue_byte(8'h00);
        queue_byte(CH_QUOTE);
        queue_byte(8'hFF);
        queue_text("\\n\\uFFFF\"");
        // bad escape letter, bad hex digit, cut escape, cut unicode, unterminated
        queue_text("\"\\q");
        queue_text("\"\\u0g");
        queue_text("\"\\");
        queue_end();
        queue_text("\"\\ua");
        queue_end();
        queue_byte(CH_QUOTE);
        queue_end();

        hold_next = 1'b1;
        while (pending_reqs.size() < STIM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    queue_end();
                else
                    queue_byte(plain_byte());
            end
            else
                queue_random_string();
        end
        stim_total = pending_reqs.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || src_if.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        error_cnt += expected_results.size();
        $display("Run covered %0d source requests and %0d results: %0d strings closed,",
                 accepted_cnt, results_cnt, strings_closed);
        $display("%0d error results, %0d mismatches.", error_results, error_cnt);
        if (error_cnt == 0)
            $display("json_string_unescape_utf8 test passed");
        else
            $display("json_string_unescape_utf8 test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/json_string_unescape_utf8.sv
bench/tb_json_string_unescape_utf8.sv
